### rtl/imhdk_pkg.sv
// Shared types and codes for the indexed min-heap block.
`default_nettype none
package imhdk_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_KEY = 2'd0,
      CMD_BUILD     = 2'd1,
      CMD_EXTRACT   = 2'd2,
      CMD_DECREASE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_EMPTY       = 2'd1,
      ST_NOT_IN_HEAP = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_FILL, S_HEAPIFY, S_LD_V, S_LD_K, S_LD_KD,
      S_SD_L, S_SD_LK, S_SD_R, S_SD_RK, S_SD_RC, S_SD_DEC, S_SD_SW, S_SD_RET,
      S_EX_TOP, S_EX_KEY, S_EX_LAST,
      S_DK_SLOT, S_DK_CHK,
      S_SU_P, S_SU_PV, S_SU_DEC, S_SU_SW,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

### rtl/imhdk_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module imhdk_ram #(
   parameter int W = 32,
   parameter int D = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [$clog2(D)-1:0] waddr,
   input  wire logic [W-1:0]         wdata,
   input  wire logic [$clog2(D)-1:0] raddr,
   output logic      [W-1:0]         rdata
);
   logic [W-1:0] mem [D];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/indexed_min_heap_decrease_key_top.sv
// Indexed binary min-heap with position map, driven by a small sequencer.
//
//  channel | ports                                   | role
//  req     | req_valid/ready, command, vertex, key   | command beat in
//  rsp     | rsp_valid/ready, out_vertex, key, status| one result beat per command
//  csr     | csr_valid/ready, csr_wdata              | vertex_count write
//
// write_key writes the key store; build fills n heap slots, then sifts down each internal
// node. extract sifts down from the root; decrease_key sifts up from the vertex's slot.
// Each step uses the one read port of each store.
// Reset clears control state only; the stores hold nothing meaningful until written.
// req_ready is low while a command is in progress; a result waiting on rsp
// holds the sequencer only at its last step.
`default_nettype none
module indexed_min_heap_decrease_key_top #(
   parameter int MAX_VERTICES = 1023,
   parameter int KEY_BITS     = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [9:0]  req_vertex,
   input  wire logic [31:0] req_new_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_out_vertex,
   output logic [31:0]      rsp_out_key,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [9:0]  csr_wdata
);
   localparam int IW = $clog2(MAX_VERTICES + 1);
   localparam int D  = MAX_VERTICES + 1;

   imhdk_pkg::state_type  state_ff, state_in;
   imhdk_pkg::cmd_type    op_ff, op_in;
   imhdk_pkg::status_type st_ff, st_in;

   logic [IW-1:0]       s_ff, s_in, vs_ff, vs_in, cv_ff, cv_in, bs_ff, bs_in, bv_ff, bv_in;
   logic [IW-1:0]       bi_ff, bi_in, count_ff, count_in;
   logic [KEY_BITS-1:0] ks_ff, ks_in, bk_ff, bk_in, kin_ff, kin_in;
   logic [9:0]          ov_ff, ov_in, vc_ff;
   logic [31:0]         ok_ff, ok_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [9:0]          rsp_vertex_ff, rsp_vertex_in;
   logic [31:0]         rsp_key_ff, rsp_key_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                h_we, p_we, k_we;
   logic [IW-1:0]       h_wa, h_wd, h_ra, h_rd, p_wa, p_wd, p_ra, p_rd, k_wa, k_ra;
   logic [KEY_BITS-1:0] k_wd, k_rd;

   logic [IW:0]         lc, rc;
   logic [IW-1:0]       nbuild, vin;
   logic                vin_ok;

   imhdk_ram #(.W(IW), .D(D)) u_heap (
      .clock(clock), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
   imhdk_ram #(.W(IW), .D(D)) u_pos (
      .clock(clock), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
   imhdk_ram #(.W(KEY_BITS), .D(D)) u_key (
      .clock(clock), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

   assign lc     = {s_ff, 1'b0};
   assign rc     = {s_ff, 1'b1};
   assign nbuild = (32'(vc_ff) > 32'(MAX_VERTICES)) ? IW'(MAX_VERTICES) : IW'(vc_ff);
   assign vin    = IW'(req_vertex);
   assign vin_ok = 32'(req_vertex) <= 32'(MAX_VERTICES);

   assign req_ready      = (state_ff == imhdk_pkg::S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_vertex = rsp_vertex_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_status     = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imhdk_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         vc_ff        <= 10'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_valid && csr_ready) begin
            vc_ff <= csr_wdata;
         end
      end
      op_ff <= op_in; st_ff <= st_in;
      s_ff <= s_in; vs_ff <= vs_in; cv_ff <= cv_in; bs_ff <= bs_in; bv_ff <= bv_in;
      bi_ff <= bi_in; ks_ff <= ks_in; bk_ff <= bk_in; kin_ff <= kin_in;
      ov_ff <= ov_in; ok_ff <= ok_in;
      rsp_vertex_ff <= rsp_vertex_in; rsp_key_ff <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in = state_ff; op_in = op_ff; st_in = st_ff;
      s_in = s_ff; vs_in = vs_ff; cv_in = cv_ff; bs_in = bs_ff; bv_in = bv_ff;
      bi_in = bi_ff; count_in = count_ff; ks_in = ks_ff; bk_in = bk_ff; kin_in = kin_ff;
      ov_in = ov_ff; ok_in = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in = rsp_vertex_ff; rsp_key_in = rsp_key_ff; rsp_status_in = rsp_status_ff;
      h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;

      unique case (state_ff)
         imhdk_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in  = imhdk_pkg::cmd_type'(req_command);
               st_in  = imhdk_pkg::ST_OK;
               ov_in  = '0;
               ok_in  = '0;
               vs_in  = vin;
               kin_in = KEY_BITS'(req_new_key);
               state_in = imhdk_pkg::S_DONE;
               unique case (imhdk_pkg::cmd_type'(req_command))
                  imhdk_pkg::CMD_WRITE_KEY: begin
                     k_we = vin_ok;
                     k_wa = vin;
                     k_wd = KEY_BITS'(req_new_key);
                  end
                  imhdk_pkg::CMD_BUILD: begin
                     count_in = nbuild;
                     bi_in    = IW'(1);
                     if (nbuild != '0) state_in = imhdk_pkg::S_FILL;
                  end
                  imhdk_pkg::CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        st_in = imhdk_pkg::ST_EMPTY;
                     end else begin
                        h_ra     = IW'(1);
                        state_in = imhdk_pkg::S_EX_TOP;
                     end
                  end
                  imhdk_pkg::CMD_DECREASE: begin
                     if (req_vertex == '0 || !vin_ok) begin
                        st_in = imhdk_pkg::ST_NOT_IN_HEAP;
                     end else begin
                        p_ra     = vin;
                        state_in = imhdk_pkg::S_DK_SLOT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         imhdk_pkg::S_FILL: begin
            h_we = 1'b1; h_wa = bi_ff; h_wd = bi_ff;
            p_we = 1'b1; p_wa = bi_ff; p_wd = bi_ff;
            if (bi_ff == count_ff) state_in = imhdk_pkg::S_HEAPIFY;
            else bi_in = bi_ff + IW'(1);
         end
         imhdk_pkg::S_HEAPIFY: begin
            bi_in    = count_ff >> 1;
            state_in = ((count_ff >> 1) == '0) ? imhdk_pkg::S_DONE : imhdk_pkg::S_LD_V;
         end
         imhdk_pkg::S_LD_V: begin
            h_ra     = bi_ff;
            state_in = imhdk_pkg::S_LD_K;
         end
         imhdk_pkg::S_LD_K: begin
            vs_in    = h_rd;
            k_ra     = h_rd;
            s_in     = bi_ff;
            state_in = imhdk_pkg::S_LD_KD;
         end
         imhdk_pkg::S_LD_KD: begin
            ks_in    = k_rd;
            state_in = imhdk_pkg::S_SD_L;
         end
         imhdk_pkg::S_SD_L: begin
            bs_in = s_ff;
            bk_in = ks_ff;
            if (lc <= {1'b0, count_ff}) begin
               h_ra     = IW'(lc);
               state_in = imhdk_pkg::S_SD_LK;
            end else begin
               state_in = imhdk_pkg::S_SD_RET;
            end
         end
         imhdk_pkg::S_SD_LK: begin
            cv_in    = h_rd;
            k_ra     = h_rd;
            state_in = imhdk_pkg::S_SD_R;
         end
         imhdk_pkg::S_SD_R: begin
            if (k_rd < ks_ff) begin
               bs_in = IW'(lc);
               bk_in = k_rd;
               bv_in = cv_ff;
            end
            if (rc <= {1'b0, count_ff}) begin
               h_ra     = IW'(rc);
               state_in = imhdk_pkg::S_SD_RK;
            end else begin
               state_in = imhdk_pkg::S_SD_DEC;
            end
         end
         imhdk_pkg::S_SD_RK: begin
            cv_in    = h_rd;
            k_ra     = h_rd;
            state_in = imhdk_pkg::S_SD_RC;
         end
         imhdk_pkg::S_SD_RC: begin
            if (k_rd < bk_ff) begin
               bs_in = IW'(rc);
               bk_in = k_rd;
               bv_in = cv_ff;
            end
            state_in = imhdk_pkg::S_SD_DEC;
         end
         imhdk_pkg::S_SD_DEC: begin
            if (bs_ff == s_ff) begin
               state_in = imhdk_pkg::S_SD_RET;
            end else begin
               h_we = 1'b1; h_wa = s_ff; h_wd = bv_ff;
               p_we = 1'b1; p_wa = bv_ff; p_wd = s_ff;
               state_in = imhdk_pkg::S_SD_SW;
            end
         end
         imhdk_pkg::S_SD_SW: begin
            h_we = 1'b1; h_wa = bs_ff; h_wd = vs_ff;
            p_we = 1'b1; p_wa = vs_ff; p_wd = bs_ff;
            s_in     = bs_ff;
            state_in = imhdk_pkg::S_SD_L;
         end
         imhdk_pkg::S_SD_RET: begin
            if (op_ff == imhdk_pkg::CMD_BUILD && bi_ff > IW'(1)) begin
               bi_in    = bi_ff - IW'(1);
               state_in = imhdk_pkg::S_LD_V;
            end else begin
               state_in = imhdk_pkg::S_DONE;
            end
         end
         imhdk_pkg::S_EX_TOP: begin
            cv_in    = h_rd;
            ov_in    = 10'(h_rd);
            k_ra     = h_rd;
            h_ra     = count_ff;
            state_in = imhdk_pkg::S_EX_KEY;
         end
         imhdk_pkg::S_EX_KEY: begin
            ok_in = 32'(k_rd);
            vs_in = h_rd;
            k_ra  = h_rd;
            h_we = 1'b1; h_wa = count_ff; h_wd = cv_ff;
            p_we = 1'b1; p_wa = cv_ff; p_wd = count_ff;
            state_in = imhdk_pkg::S_EX_LAST;
         end
         imhdk_pkg::S_EX_LAST: begin
            ks_in = k_rd;
            h_we = 1'b1; h_wa = IW'(1); h_wd = vs_ff;
            p_we = 1'b1; p_wa = vs_ff; p_wd = IW'(1);
            count_in = count_ff - IW'(1);
            s_in     = IW'(1);
            state_in = (count_ff == IW'(1)) ? imhdk_pkg::S_DONE : imhdk_pkg::S_SD_L;
         end
         imhdk_pkg::S_DK_SLOT: begin
            s_in = p_rd;
            if (p_rd == '0 || p_rd > count_ff) begin
               st_in    = imhdk_pkg::ST_NOT_IN_HEAP;
               state_in = imhdk_pkg::S_DONE;
            end else begin
               h_ra     = p_rd;
               state_in = imhdk_pkg::S_DK_CHK;
            end
         end
         imhdk_pkg::S_DK_CHK: begin
            if (h_rd != vs_ff) begin
               st_in    = imhdk_pkg::ST_NOT_IN_HEAP;
               state_in = imhdk_pkg::S_DONE;
            end else begin
               k_we = 1'b1; k_wa = vs_ff; k_wd = kin_ff;
               ks_in    = kin_ff;
               state_in = imhdk_pkg::S_SU_P;
            end
         end
         imhdk_pkg::S_SU_P: begin
            if (s_ff <= IW'(1)) begin
               state_in = imhdk_pkg::S_DONE;
            end else begin
               h_ra     = s_ff >> 1;
               state_in = imhdk_pkg::S_SU_PV;
            end
         end
         imhdk_pkg::S_SU_PV: begin
            cv_in    = h_rd;
            k_ra     = h_rd;
            state_in = imhdk_pkg::S_SU_DEC;
         end
         imhdk_pkg::S_SU_DEC: begin
            if (ks_ff < k_rd) begin
               h_we = 1'b1; h_wa = s_ff; h_wd = cv_ff;
               p_we = 1'b1; p_wa = cv_ff; p_wd = s_ff;
               state_in = imhdk_pkg::S_SU_SW;
            end else begin
               state_in = imhdk_pkg::S_DONE;
            end
         end
         imhdk_pkg::S_SU_SW: begin
            h_we = 1'b1; h_wa = s_ff >> 1; h_wd = vs_ff;
            p_we = 1'b1; p_wa = vs_ff; p_wd = s_ff >> 1;
            s_in     = s_ff >> 1;
            state_in = imhdk_pkg::S_SU_P;
         end
         imhdk_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = ov_ff;
               rsp_key_in    = ok_ff;
               rsp_status_in = st_ff;
               state_in      = imhdk_pkg::S_IDLE;
            end
         end
         default: state_in = imhdk_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire
